FILE: src/ssc_pkg.sv
// shared types, codes and the commutation table of the six-step sequencer
package ssc_pkg;

    localparam int STEP_W   = 3;
    localparam int NUM_STEPS = 6;
    localparam int WAIT_W   = 24;
    localparam int THR_W    = 10;
    localparam int DIV_BITS = 12;
    localparam int DIVR_W   = 9;
    localparam int PAT_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIV_BITS-1:0] THR_NUM  = 12'd3000;
    localparam logic [DIVR_W-1:0]   THR_BIAS = 9'd5;

    localparam logic [15:0] START_DELAY_RST = 16'd4000;
    localparam logic [23:0] ALIGN_TIME_RST  = 24'd100000;
    localparam logic [7:0]  RAMP_STEP_RST   = 8'd70;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_ADVANCE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ALIGN = 2'd1,
        MODE_RAMP  = 2'd2,
        MODE_RUN   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELAY = 2'd0,
        CFG_ALIGN_TIME  = 2'd1,
        CFG_RAMP_STEP   = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_DIV   = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;        // load duty, interval, align wait, kick divider
        logic stop;         // gates off, wait cleared
        logic commutate;    // apply next step
        logic wait_dec;     // saturating wait decrement
        logic wait_reload;  // wait from ramp interval, interval steps down
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic wait_le1;     // wait reaches zero on this tick
        logic ivl_gt_thr;   // ramp still above threshold
        logic div_done;
    } t_stat;

    // pattern bits: [8:6] low, [5:3] high, [2:1] sense phase, [0] rising
    function automatic logic [PAT_W-1:0] step_pattern(input logic [STEP_W-1:0] s);
        logic [PAT_W-1:0] p;
        case (s)
            3'd0:    p = {3'b010, 3'b100, 2'd2, 1'b1};
            3'd1:    p = {3'b001, 3'b100, 2'd1, 1'b0};
            3'd2:    p = {3'b001, 3'b010, 2'd0, 1'b1};
            3'd3:    p = {3'b100, 3'b010, 2'd2, 1'b0};
            3'd4:    p = {3'b100, 3'b001, 2'd1, 1'b1};
            3'd5:    p = {3'b010, 3'b001, 2'd0, 1'b0};
            default: p = {3'b010, 3'b100, 2'd2, 1'b1};
        endcase
        return p;
    endfunction

endpackage

FILE: src/six_step_commutation_sequencer_core.sv
// latency: the result of an item is valid in the cycle after its transaction
// tick, stop and advance items leave the controller ready for the next item
// a start item holds off input while the 12-step threshold divider runs
// a waiting result holds off input; the next item can be taken in the cycle the result leaves
// reset (synchronous, active low): idle, gates off, step 0, registers to defaults
module six_step_commutation_sequencer_core import ssc_pkg::*; #(
    parameter int DELAY_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_supply_voltage,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_low_side,
    output logic [2:0]            o_high_side,
    output logic [1:0]            o_sense_phase,
    output logic                  o_rising_edge,
    output logic                  o_sense_enabled,
    output logic [7:0]            o_pwm_duty,
    output logic [1:0]            o_run_mode,
    output logic                  o_commutated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd             cmd;
    t_stat            stat;
    logic [PAT_W-1:0] pattern;

    assign o_cfg_ready = i_rst_n;

    ssc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd),
        .i_stat       (stat),
        .o_run_mode   (o_run_mode),
        .o_commutated (o_commutated)
    );

    ssc_dp #(
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_supply_voltage (i_supply_voltage),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_pattern        (pattern),
        .o_duty           (o_pwm_duty)
    );

    assign o_low_side      = pattern[8:6];
    assign o_high_side     = pattern[5:3];
    assign o_sense_phase   = pattern[2:1];
    assign o_rising_edge   = pattern[0];
    assign o_sense_enabled = (o_run_mode == MODE_RUN);

    // a fresh step drives exactly one low and one high gate
    a_comm_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_commutated |-> $onehot(o_low_side) && $onehot(o_high_side))
        else $error("commutation applied a malformed gate pattern");

    // idle means every gate is off
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_mode == MODE_IDLE |-> o_low_side == 3'b000 && o_high_side == 3'b000)
        else $error("gates driven while idle");

    // start holds off input until the threshold is computed
    a_start_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_opcode == OP_START |=> !o_in_ready)
        else $error("input taken while threshold divider busy");

endmodule

FILE: src/ssc_div.sv
// restoring divider, one quotient bit a cycle, for the ramp threshold
module ssc_div import ssc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [THR_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(DIV_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_BITS - 1);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIV_BITS-1:0] r_quo, n_quo;
    logic [DIVR_W-1:0] r_rem, n_rem;
    logic [DIVR_W-1:0] r_dvs, n_dvs;
    logic              r_done, n_done;
    logic [DIVR_W:0]   trial;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_quo[DIV_BITS-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = THR_NUM;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DIVR_W'(trial - {1'b0, r_dvs});
                n_quo = {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVR_W-1:0];
                n_quo = {r_quo[DIV_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[THR_W-1:0];

endmodule

FILE: src/ssc_dp.sv
// datapath: configuration, step, pattern, duty, ramp interval, threshold and wait counter
module ssc_dp import ssc_pkg::*; #(
    parameter int DELAY_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [7:0]            i_supply_voltage,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [PAT_W-1:0]      o_pattern,
    output logic [7:0]            o_duty
);

    logic [15:0]           r_start_delay;
    logic [23:0]           r_align_time;
    logic [7:0]            r_ramp_step;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [PAT_W-1:0]      r_pat, n_pat;
    logic [7:0]            r_duty, n_duty;
    logic [DELAY_BITS-1:0] r_ivl, n_ivl;
    logic [THR_W-1:0]      r_thr, n_thr;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [STEP_W-1:0]     cur_step;
    logic                  div_done;
    logic [THR_W-1:0]      quotient;

    ssc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_divisor  ({1'b0, i_supply_voltage} + THR_BIAS),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay <= START_DELAY_RST;
            r_align_time  <= ALIGN_TIME_RST;
            r_ramp_step   <= RAMP_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_DELAY: r_start_delay <= i_cfg_data[15:0];
                CFG_ALIGN_TIME:  r_align_time  <= i_cfg_data[23:0];
                CFG_RAMP_STEP:   r_ramp_step   <= i_cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign cur_step = (r_step < STEP_W'(NUM_STEPS)) ? r_step : '0;

    always_comb begin
        n_step = r_step;
        n_pat  = r_pat;
        n_duty = r_duty;
        n_ivl  = r_ivl;
        n_thr  = r_thr;
        n_wait = r_wait;
        if (i_cmd.commutate) begin
            n_pat  = step_pattern(cur_step);
            n_step = (cur_step == STEP_W'(NUM_STEPS - 1)) ? '0 : cur_step + 1'b1;
        end
        if (i_cmd.start) begin
            n_duty = (r_ramp_step > i_supply_voltage) ? r_ramp_step - i_supply_voltage : '0;
            n_ivl  = DELAY_BITS'(r_start_delay);
            n_wait = r_align_time;
        end
        if (i_cmd.stop) begin
            n_pat  = '0;
            n_wait = '0;
        end
        if (i_cmd.wait_dec) begin
            n_wait = (r_wait != '0) ? r_wait - 1'b1 : '0;
        end
        if (i_cmd.wait_reload) begin
            n_wait = WAIT_W'(r_ivl);
            n_ivl  = (r_ivl > DELAY_BITS'(r_ramp_step)) ?
                     r_ivl - DELAY_BITS'(r_ramp_step) : '0;
        end
        if (div_done) begin
            n_thr = quotient;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pat  <= '0;
            r_duty <= '0;
            r_ivl  <= '0;
            r_thr  <= '0;
            r_wait <= '0;
        end else begin
            r_step <= n_step;
            r_pat  <= n_pat;
            r_duty <= n_duty;
            r_ivl  <= n_ivl;
            r_thr  <= n_thr;
            r_wait <= n_wait;
        end
    end

    assign o_stat.wait_le1   = (r_wait[WAIT_W-1:1] == '0);
    assign o_stat.ivl_gt_thr = (r_ivl > DELAY_BITS'(r_thr));
    assign o_stat.div_done   = div_done;
    assign o_pattern = r_pat;
    assign o_duty    = r_duty;

endmodule

FILE: src/ssc_ctrl.sv
// controller: transaction handshake, run mode and divider wait
module ssc_ctrl import ssc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd,
    input  t_stat      i_stat,
    output logic [1:0] o_run_mode,
    output logic       o_commutated
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_out_valid, n_out_valid;
    logic   r_comm, n_comm;
    logic   accept;
    t_op    op;

    assign op = t_op'(i_opcode);
    assign o_in_ready = i_rst_n && (r_state == ST_READY) && (!r_out_valid || i_out_ready);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_mode      = r_mode;
        n_comm      = r_comm;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_READY: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_comm      = 1'b0;
                    case (op)
                        OP_START: begin
                            o_cmd.start     = 1'b1;
                            o_cmd.commutate = 1'b1;
                            n_comm          = 1'b1;
                            n_mode          = MODE_ALIGN;
                            n_state         = ST_DIV;
                        end
                        OP_STOP: begin
                            o_cmd.stop = 1'b1;
                            n_mode     = MODE_IDLE;
                        end
                        OP_ADVANCE: begin
                            if (r_mode == MODE_RUN) begin
                                o_cmd.commutate = 1'b1;
                                n_comm          = 1'b1;
                            end
                        end
                        default: begin
                            if (r_mode == MODE_ALIGN || r_mode == MODE_RAMP) begin
                                o_cmd.wait_dec = 1'b1;
                                if (i_stat.wait_le1) begin
                                    if (i_stat.ivl_gt_thr) begin
                                        o_cmd.commutate   = 1'b1;
                                        o_cmd.wait_reload = 1'b1;
                                        n_comm            = 1'b1;
                                        n_mode            = MODE_RAMP;
                                    end else begin
                                        n_mode = MODE_RUN;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // threshold must be in place before the next tick is judged
                if (i_stat.div_done) begin
                    n_state = ST_READY;
                end
            end
            default: n_state = ST_READY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_READY;
            r_mode      <= MODE_IDLE;
            r_out_valid <= 1'b0;
            r_comm      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_comm      <= n_comm;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_mode   = r_mode;
    assign o_commutated = r_comm;

endmodule
